>>> src/eucdec_pkg.sv
package eucdec_pkg;

  localparam int INDEX_W = 14;
  localparam int CODE_W  = 21;

  // item kinds on the input tuser bit
  localparam logic OP_TABLE = 1'b0;
  localparam logic OP_BYTE  = 1'b1;

  // byte classes
  localparam logic [7:0] ASCII_LIMIT = 8'h80;
  localparam logic [7:0] SS2         = 8'h8E;
  localparam logic [7:0] SS3         = 8'h8F;
  localparam logic [7:0] TRAIL_MIN   = 8'hA1;
  localparam logic [7:0] LEAD_MAX    = 8'hF4;
  localparam logic [7:0] KANA_MAX    = 8'hDF;
  localparam logic [7:0] TRAIL_MAX   = 8'hFE;
  localparam logic [7:0] SS3_ROW_MIN = 8'hA2;
  localparam logic [7:0] SS3_ROW_MAX = 8'hED;

  // table regions
  localparam logic [INDEX_W-1:0] JIS0208_BASE = 14'd256;
  localparam logic [INDEX_W-1:0] JIS0212_BASE = 14'd8152;
  localparam logic [INDEX_W-1:0] ROW_LEN      = 14'd94;

  // bytes held by the decoder
  localparam logic [1:0] HELD_NONE = 2'd0;
  localparam logic [1:0] HELD_ONE  = 2'd1;
  localparam logic [1:0] HELD_TWO  = 2'd2;

  typedef enum logic [2:0] {
    ERR_NONE         = 3'd0,
    ERR_TRUNC_SECOND = 3'd1,
    ERR_TRUNC_THIRD  = 3'd2,
    ERR_BAD_SECOND2  = 3'd3,
    ERR_BAD_SECOND3  = 3'd4,
    ERR_BAD_THIRD    = 3'd5,
    ERR_BAD_LEAD     = 3'd6
  } err_t;

  // one decoded result waiting on the table read
  typedef struct packed {
    err_t       err;
    logic [1:0] consumed;
    logic       from_table;
    logic [6:0] ascii;
  } desc_t;

endpackage

>>> src/euc_jp_to_utf8_decoder_core.sv
// channel  dir  fields (lowest bit first)
// s_*      in   tuser: operation; tdata: table_index, table_value, byte_value; tlast: is_last
// m_*      out  tdata: utf8_byte, bytes_consumed; tuser: error_code; tlast: last_of_run
//
// one input item per cycle while results keep up; a character holds the output register
// until all of its utf-8 bytes (1 to 4) are taken, so the output byte serializer sets the rate
// every result is registered in the lookup stage (registered code table read) and then in
// the serializer stage, which offers its first byte
// reset clears the decoder state and the pipeline; the code table is not cleared
// input stalls, table loads included, while the lookup stage holds a result that cannot move on
module euc_jp_to_utf8_decoder_core
  import eucdec_pkg::*;
#(
  parameter int TABLE_DEPTH = 16384
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,   // table_index[13:0], table_value[34:14], byte_value[42:35]
  input  logic [0:0]  s_tuser,   // operation[0]
  input  logic        s_tlast,   // is_last
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // utf8_byte[7:0], bytes_consumed[9:8]
  output logic [2:0]  m_tuser,   // error_code[2:0]
  output logic        m_tlast    // last_of_run
);

  localparam int AW = $clog2(TABLE_DEPTH);

  // input fields
  logic [INDEX_W-1:0] in_index;
  logic [CODE_W-1:0]  in_value;
  logic [7:0]         in_byte;
  logic               in_last;
  logic               accept;
  logic               is_byte;

  assign in_index = s_tdata[13:0];
  assign in_value = s_tdata[34:14];
  assign in_byte  = s_tdata[42:35];
  assign in_last  = s_tlast;
  assign accept   = s_tvalid && s_tready;
  assign is_byte  = (s_tuser[0] == OP_BYTE);

  // decoder state
  logic [7:0] lead, lead_next;
  logic [7:0] second, second_next;
  logic [1:0] held, held_next;
  logic       skip, skip_next;

  // decode of the byte at the input
  logic               dec_result;
  logic               dec_lookup;
  err_t               dec_err;
  logic [1:0]         dec_cons;
  logic [INDEX_W-1:0] dec_addr;
  logic [6:0]         row;
  logic [6:0]         col;
  logic               trail_ok;

  // lookup stage (table read in flight) and serializer stage
  logic        s1_valid;
  desc_t       s1;
  logic        s1_move;
  logic        s2_valid;
  logic [7:0]  s2_bytes [4];
  logic [1:0]  s2_idx;
  logic [1:0]  s2_last;
  logic [1:0]  s2_cons;
  err_t        s2_err;
  logic        s2_done;

  // table memory
  logic              tbl_we;
  logic              tbl_re;
  logic [CODE_W-1:0] tbl_rdata;

  // encoder
  logic [CODE_W-1:0] cp;
  logic [7:0]        enc_bytes [4];
  logic [1:0]        enc_last;

  // row and column inside a 94-wide region; only used when the bytes are in range
  assign row      = 7'(((held == HELD_TWO) ? second : lead) - TRAIL_MIN);
  assign col      = 7'(in_byte - TRAIL_MIN);
  assign trail_ok = (in_byte >= TRAIL_MIN) && (in_byte <= TRAIL_MAX);

  always_comb begin
    dec_result  = 1'b0;
    dec_lookup  = 1'b0;
    dec_err     = ERR_NONE;
    dec_cons    = 2'd0;
    dec_addr    = '0;
    lead_next   = lead;
    second_next = second;
    held_next   = held;
    skip_next   = skip;
    if (skip) begin
      // dropping bytes up to the end of the string
      if (in_last) begin
        skip_next = 1'b0;
      end
    end else begin
      case (held)
        HELD_NONE: begin
          if (in_byte < ASCII_LIMIT) begin
            dec_result = 1'b1;
            dec_cons   = 2'd1;
          end else if (in_last) begin
            dec_err = ERR_TRUNC_SECOND;
          end else begin
            lead_next = in_byte;
            held_next = HELD_ONE;
          end
        end
        HELD_ONE: begin
          if (lead == SS2) begin
            // half-width kana
            if (in_byte < TRAIL_MIN || in_byte > KANA_MAX) begin
              dec_err = ERR_BAD_SECOND2;
            end else begin
              dec_result = 1'b1;
              dec_lookup = 1'b1;
              dec_cons   = 2'd2;
              dec_addr   = INDEX_W'(in_byte);
            end
          end else if (lead >= TRAIL_MIN && lead <= LEAD_MAX) begin
            if (!trail_ok) begin
              dec_err = ERR_BAD_SECOND2;
            end else begin
              dec_result = 1'b1;
              dec_lookup = 1'b1;
              dec_cons   = 2'd2;
              dec_addr   = JIS0208_BASE + INDEX_W'(row) * ROW_LEN + INDEX_W'(col);
            end
          end else if (lead == SS3) begin
            if (in_last) begin
              dec_err = ERR_TRUNC_THIRD;
            end else begin
              second_next = in_byte;
              held_next   = HELD_TWO;
            end
          end else begin
            dec_err = ERR_BAD_LEAD;
          end
        end
        HELD_TWO: begin
          if (second < SS3_ROW_MIN || second > SS3_ROW_MAX) begin
            dec_err = ERR_BAD_SECOND3;
          end else if (!trail_ok) begin
            dec_err = ERR_BAD_THIRD;
          end else begin
            dec_result = 1'b1;
            dec_lookup = 1'b1;
            dec_cons   = 2'd3;
            dec_addr   = JIS0212_BASE + INDEX_W'(row) * ROW_LEN + INDEX_W'(col);
          end
        end
        default: begin
          held_next = HELD_NONE;
        end
      endcase
      if (dec_err != ERR_NONE) begin
        // a single error result, then drop the rest of the string
        dec_result  = 1'b1;
        held_next   = HELD_NONE;
        lead_next   = '0;
        second_next = '0;
        skip_next   = !in_last;
      end else if (dec_result) begin
        held_next   = HELD_NONE;
        lead_next   = '0;
        second_next = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lead   <= '0;
      second <= '0;
      held   <= HELD_NONE;
      skip   <= 1'b0;
    end else if (accept && is_byte) begin
      lead   <= lead_next;
      second <= second_next;
      held   <= held_next;
      skip   <= skip_next;
    end
  end

  // table port: loads write, lookups read; one item per cycle keeps them apart
  assign tbl_we = accept && !is_byte && (32'(in_index) < TABLE_DEPTH);
  assign tbl_re = accept && is_byte && dec_lookup;

  eucdec_ram #(
    .WIDTH (CODE_W),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (AW'(in_index)),
    .wdata (in_value),
    .re    (tbl_re),
    .raddr (AW'(dec_addr)),
    .rdata (tbl_rdata)
  );

  // handshake: the lookup stage frees when the serializer can take it
  assign s2_done  = m_tvalid && m_tready && (s2_idx == s2_last);
  assign s1_move  = s1_valid && (!s2_valid || s2_done);
  assign s_tready = !s1_valid || s1_move;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept && is_byte && dec_result) begin
      s1_valid <= 1'b1;
    end else if (s1_move) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && is_byte && dec_result) begin
      s1.err        <= dec_err;
      s1.consumed   <= (dec_err == ERR_NONE) ? dec_cons : 2'd0;
      s1.from_table <= dec_lookup;
      s1.ascii      <= in_byte[6:0];
    end
  end

  // utf-8 encoding of the code point (the table word is valid while s1 waits)
  assign cp = s1.from_table ? tbl_rdata : CODE_W'(s1.ascii);

  always_comb begin
    enc_bytes[0] = '0;
    enc_bytes[1] = '0;
    enc_bytes[2] = '0;
    enc_bytes[3] = '0;
    enc_last     = 2'd0;
    if (s1.err != ERR_NONE) begin
      enc_last = 2'd0;
    end else if (cp < 21'h80) begin
      enc_bytes[0] = cp[7:0];
    end else if (cp < 21'h800) begin
      enc_bytes[0] = {3'b110, cp[10:6]};
      enc_bytes[1] = {2'b10, cp[5:0]};
      enc_last     = 2'd1;
    end else if (cp < 21'h10000) begin
      enc_bytes[0] = {4'b1110, cp[15:12]};
      enc_bytes[1] = {2'b10, cp[11:6]};
      enc_bytes[2] = {2'b10, cp[5:0]};
      enc_last     = 2'd2;
    end else begin
      enc_bytes[0] = {5'b11110, cp[20:18]};
      enc_bytes[1] = {2'b10, cp[17:12]};
      enc_bytes[2] = {2'b10, cp[11:6]};
      enc_bytes[3] = {2'b10, cp[5:0]};
      enc_last     = 2'd3;
    end
  end

  // output serializer: one utf-8 byte per accepted output item
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
      s2_idx   <= 2'd0;
    end else if (s1_move) begin
      s2_valid <= 1'b1;
      s2_idx   <= 2'd0;
    end else if (s2_done) begin
      s2_valid <= 1'b0;
    end else if (m_tvalid && m_tready) begin
      s2_idx <= s2_idx + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      s2_bytes <= enc_bytes;
      s2_last  <= enc_last;
      s2_cons  <= s1.consumed;
      s2_err   <= s1.err;
    end
  end

  assign m_tvalid = s2_valid;
  assign m_tdata  = {6'd0, (s2_idx == 2'd0) ? s2_cons : 2'd0, s2_bytes[s2_idx]};
  assign m_tuser  = s2_err;
  assign m_tlast  = (s2_idx == s2_last);

endmodule

>>> src/eucdec_ram.sv
module eucdec_ram #(
  parameter int WIDTH = 21,
  parameter int DEPTH = 16384
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> src/eucdec_checker.sv
module eucdec_checker
  import eucdec_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [15:0] m_tdata,
  input logic [2:0]  m_tuser,
  input logic        m_tlast
);

  // nothing left over in the output register after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output valid right after reset");

  // an error is a single zero byte that ends its run
  a_error_shape: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser != ERR_NONE) |-> (m_tdata == 16'd0 && m_tlast))
    else $error("malformed error result");

  // a stalled output holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)
                                 && $stable(m_tlast)))
    else $error("output changed while stalled");

  // bytes following the first byte of a character carry no count
  a_cons_after_first: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tready && !m_tlast) |=> (!m_tvalid || m_tdata[9:8] == 2'd0))
    else $error("bytes_consumed on a continuation byte");

endmodule

bind euc_jp_to_utf8_decoder_core eucdec_checker u_eucdec_checker (.*);
